### rtl/swmf_pkg.sv
// shared types and constants of the sliding window median filter
`default_nettype none

package swmf_pkg;

	localparam int MAX_WINDOW_DEF = 32;
	localparam int SAMPLE_W       = 16;
	localparam int MEDIAN_W       = 17;
	localparam int WS_W           = 6;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = 3;

	localparam logic [WS_W-1:0]   WS_RESET            = 6'd5;
	localparam logic [ADDR_W-1:0] REG_WINDOW_SIZE_ADR = 3'd0;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	// command broadcast to every cell of the sorted chain
	typedef struct packed {
		logic                       clear;
		logic                       evict;
		logic                       insert;
		logic signed [SAMPLE_W-1:0] sample;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/swmf_cell.sv
// one cell of the sorted chain: holds a sample, its age and a valid flag
`default_nettype none

module swmf_cell
	import swmf_pkg::*;
#(
	parameter int AW = 6
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire cell_ctrl_t            ctrl,
	input  wire [AW-1:0]               oldest_age,
	// neighbor below (smaller values)
	input  wire                        lo_valid,
	input  wire signed [SAMPLE_W-1:0]  lo_value,
	input  wire [AW-1:0]               lo_age,
	input  wire                        lo_above,
	input  wire                        lo_removed,
	// neighbor above (larger values)
	input  wire                        hi_valid,
	input  wire signed [SAMPLE_W-1:0]  hi_value,
	input  wire [AW-1:0]               hi_age,
	output logic                       valid,
	output logic signed [SAMPLE_W-1:0] value,
	output logic [AW-1:0]              age,
	output logic                       above,
	output logic                       removed
);

	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic [AW-1:0]              age_q;

	// new sample lands at or below this cell
	assign above   = !valid_q || (value_q > ctrl.sample);
	// oldest sample sits here or somewhere below
	assign removed = lo_removed || (valid_q && (age_q == oldest_age));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.evict) begin
			if (removed) valid_q <= hi_valid;
		end else if (ctrl.insert) begin
			if (above) valid_q <= lo_above ? lo_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.evict) begin
			if (removed) begin
				value_q <= hi_value;
				age_q   <= hi_age;
			end
		end else if (ctrl.insert) begin
			if (above && lo_above) begin
				value_q <= lo_value;
				age_q   <= lo_age + AW'(1);
			end else if (above) begin
				value_q <= ctrl.sample;
				age_q   <= '0;
			end else begin
				age_q   <= age_q + AW'(1);
			end
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

endmodule

`default_nettype wire

### rtl/sliding_window_median_filter.sv
// top level: running median over a sorted chain of sample cells
// a push inserts, reads the two middle taps, then loads its result and returns to idle
// eviction steps first drop samples from the oldest end until fewer than the window hold
// a clear empties the window; a result still stalled holds the sequencer in its last read
// the sequence is: eviction steps, one insert step, two median reads
// reset empties the window and sets window_size to 5
`default_nettype none

module sliding_window_median_filter
	import swmf_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CW = $clog2(MAX_WINDOW + 1),
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration port
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [ADDR_W-1:0]           paddr,
	input  wire [DATA_W-1:0]           pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	// input channel
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        opcode,
	input  wire signed [SAMPLE_W-1:0]  sample,
	// result channel
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [MEDIAN_W-1:0] median_x2,
	output logic [CW-1:0]              fill_count
);

	localparam int XW = (CW > WS_W) ? CW : WS_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EVICT  = 5'b00010,
		ST_INSERT = 5'b00100,
		ST_RD_LO  = 5'b01000,
		ST_RD_HI  = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [WS_W-1:0]            ws_q;
	logic [CW-1:0]              held_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] lo_q;
	logic                       out_valid_q;
	logic signed [MEDIAN_W-1:0] median_q;
	logic [CW-1:0]              fill_q;

	logic       in_xfer;
	logic       out_free;
	logic [CW-1:0] eff_win;
	logic [CW-1:0] held_dec;
	logic [CW-1:0] mid_idx;
	logic [IW-1:0] rd_idx;
	logic signed [SAMPLE_W-1:0] rd_value;
	cell_ctrl_t ctrl;

	// chain wiring
	logic                       c_valid   [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] c_value   [MAX_WINDOW];
	logic [CW-1:0]              c_age     [MAX_WINDOW];
	logic                       c_above   [MAX_WINDOW];
	logic                       c_removed [MAX_WINDOW];

	// register port: one register, always ready
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr == REG_WINDOW_SIZE_ADR) prdata = DATA_W'(ws_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr == REG_WINDOW_SIZE_ADR)) begin
			ws_q <= pwdata[WS_W-1:0];
		end
	end

	// window size clamped to 1..MAX_WINDOW
	always_comb begin
		if (ws_q == '0) begin
			eff_win = CW'(1);
		end else if (XW'(ws_q) > XW'(MAX_WINDOW)) begin
			eff_win = CW'(MAX_WINDOW);
		end else begin
			eff_win = CW'(ws_q);
		end
	end

	assign held_dec = held_q - CW'(1);
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// cell commands
	always_comb begin
		ctrl.clear  = in_xfer && (opcode_t'(opcode) == OP_CLEAR);
		ctrl.evict  = (state_q == ST_EVICT);
		ctrl.insert = (state_q == ST_INSERT);
		ctrl.sample = sample_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			logic                       lo_valid_w, lo_above_w, lo_removed_w, hi_valid_w;
			logic signed [SAMPLE_W-1:0] lo_value_w, hi_value_w;
			logic [CW-1:0]              lo_age_w, hi_age_w;

			if (gi == 0) begin : g_bottom
				// new sample enters from below at the bottom cell
				assign lo_valid_w   = 1'b1;
				assign lo_value_w   = '0;
				assign lo_age_w     = '0;
				assign lo_above_w   = 1'b0;
				assign lo_removed_w = 1'b0;
			end else begin : g_mid_lo
				assign lo_valid_w   = c_valid[gi-1];
				assign lo_value_w   = c_value[gi-1];
				assign lo_age_w     = c_age[gi-1];
				assign lo_above_w   = c_above[gi-1];
				assign lo_removed_w = c_removed[gi-1];
			end

			if (gi == MAX_WINDOW - 1) begin : g_top
				assign hi_valid_w = 1'b0;
				assign hi_value_w = '0;
				assign hi_age_w   = '0;
			end else begin : g_mid_hi
				assign hi_valid_w = c_valid[gi+1];
				assign hi_value_w = c_value[gi+1];
				assign hi_age_w   = c_age[gi+1];
			end

			swmf_cell #(
				.AW(CW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.oldest_age (held_dec),
				.lo_valid   (lo_valid_w),
				.lo_value   (lo_value_w),
				.lo_age     (lo_age_w),
				.lo_above   (lo_above_w),
				.lo_removed (lo_removed_w),
				.hi_valid   (hi_valid_w),
				.hi_value   (hi_value_w),
				.hi_age     (hi_age_w),
				.valid      (c_valid[gi]),
				.value      (c_value[gi]),
				.age        (c_age[gi]),
				.above      (c_above[gi]),
				.removed    (c_removed[gi])
			);
		end
	endgenerate

	// median taps: lower middle first, then upper middle
	assign mid_idx = held_q >> 1;
	always_comb begin
		if ((state_q == ST_RD_LO) && !held_q[0]) begin
			rd_idx = IW'(mid_idx - CW'(1));
		end else begin
			rd_idx = IW'(mid_idx);
		end
	end

	always_comb begin
		rd_value = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (rd_idx == IW'(i)) rd_value = c_value[i];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (opcode_t'(opcode) == OP_CLEAR) begin
							held_q <= '0;
						end else if (held_q >= eff_win) begin
							state_q <= ST_EVICT;
						end else begin
							state_q <= ST_INSERT;
						end
					end
				end
				ST_EVICT: begin
					held_q <= held_dec;
					if (held_dec < eff_win) state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					held_q  <= held_q + CW'(1);
					state_q <= ST_RD_LO;
				end
				ST_RD_LO: begin
					state_q <= ST_RD_HI;
				end
				ST_RD_HI: begin
					// hold here until the result register is free
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid: loaded from the last read step, dropped once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RD_HI) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) sample_q <= sample;
		if (state_q == ST_RD_LO) lo_q <= rd_value;
		if ((state_q == ST_RD_HI) && out_free) begin
			median_q <= MEDIAN_W'(lo_q) + MEDIAN_W'(rd_value);
			fill_q   <= held_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign median_x2  = median_q;
	assign fill_count = fill_q;

endmodule

`default_nettype wire
